FILE: hw/rtl/dfe_pkg.sv
// package for the delimited field escaper
// item, configuration and register index types plus character constants
// no dependencies
package dfe_pkg;

  localparam int unsigned SEP_HW_MAX = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ESCAPE_CHAR     = 3'd0,
    REG_QUOTE_CHAR      = 3'd1,
    REG_FIELD_SEP_BYTES = 3'd2,
    REG_FIELD_SEP_LEN   = 3'd3,
    REG_LINE_SEP_BYTES  = 3'd4,
    REG_LINE_SEP_LEN    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  escape_char;
    logic [7:0]  quote_char;
    logic [31:0] field_sep_bytes;
    logic [2:0]  field_sep_len;
    logic [31:0] line_sep_bytes;
    logic [2:0]  line_sep_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       field_start;
    logic       field_end;
    logic       is_null;
    logic       enclose_field;
    logic       row_end;
  } item_t;

endpackage

FILE: hw/rtl/dfe_ifs.sv
// valid/ready channel interfaces for the delimited field escaper
// input item channel and output byte channel; no dependencies
interface dfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       field_start;
  logic       field_end;
  logic       is_null;
  logic       enclose_field;
  logic       row_end;

  modport source (output valid, data_byte, has_byte, field_start, field_end, is_null,
                  enclose_field, row_end, input ready);
  modport sink (input valid, data_byte, has_byte, field_start, field_end, is_null,
                enclose_field, row_end, output ready);
endinterface

interface dfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

FILE: hw/rtl/dfe_cfg_regs.sv
// configuration register file of the delimited field escaper
// depends on dfe_pkg
module dfe_cfg_regs
  import dfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_char     <= CH_BSLASH;
      cfg_r.quote_char      <= CH_NUL;
      cfg_r.field_sep_bytes <= 32'(CH_TAB);
      cfg_r.field_sep_len   <= 3'd1;
      cfg_r.line_sep_bytes  <= 32'(CH_NL);
      cfg_r.line_sep_len    <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE_CHAR:     cfg_r.escape_char     <= cfg_data[7:0];
        REG_QUOTE_CHAR:      cfg_r.quote_char      <= cfg_data[7:0];
        REG_FIELD_SEP_BYTES: cfg_r.field_sep_bytes <= cfg_data[31:0];
        REG_FIELD_SEP_LEN:   cfg_r.field_sep_len   <= cfg_data[2:0];
        REG_LINE_SEP_BYTES:  cfg_r.line_sep_bytes  <= cfg_data[31:0];
        REG_LINE_SEP_LEN:    cfg_r.line_sep_len    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/dfe_expand.sv
// input register and run builder: turns one registered item into its
// escaped byte run; depends on dfe_pkg and dfe_ifs
module dfe_expand
  import dfe_pkg::*;
#(
  parameter int unsigned SEP_BYTES_MAX = 4,
  parameter int unsigned RUN_MAX       = 8,
  parameter int unsigned CNT_W         = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  dfe_in_if.sink                      in_ch,
  input  logic                        slot_free,
  output logic                        load,
  output logic [RUN_MAX-1:0][7:0]     run_bytes,
  output logic [CNT_W-1:0]            run_cnt
);

  localparam int unsigned LIM = (SEP_BYTES_MAX < SEP_HW_MAX) ? SEP_BYTES_MAX : SEP_HW_MAX;
  localparam logic [2:0]  LIM_L = 3'(LIM);

  logic       in_valid_r;
  item_t      item_r;
  logic       take;
  logic       enc_on;
  logic       special;
  logic [3:0][7:0] head;
  logic [2:0] head_n;
  logic [2:0] sep_len;
  logic [2:0] sep_n;
  logic [3:0][7:0] sep_word;
  logic [2:0] k;

  always_comb begin
    enc_on  = item_r.enclose_field && (cfg.quote_char != CH_NUL);
    special = (item_r.data_byte == CH_TAB) || (item_r.data_byte == CH_NL) ||
              (item_r.data_byte == cfg.escape_char) ||
              ((cfg.quote_char != CH_NUL) && (item_r.data_byte == cfg.quote_char));
    head   = '0;
    head_n = '0;
    if (item_r.is_null) begin
      head[0] = cfg.escape_char;
      head[1] = CH_N;
      head_n  = 3'd2;
    end else begin
      if (item_r.field_start && enc_on) begin
        head[head_n[1:0]] = cfg.quote_char;
        head_n = head_n + 3'd1;
      end
      if (item_r.has_byte) begin
        if (item_r.data_byte == CH_NUL) begin
          head[head_n[1:0]] = cfg.escape_char;
          head_n = head_n + 3'd1;
          head[head_n[1:0]] = CH_ZERO;
          head_n = head_n + 3'd1;
        end else if (special) begin
          head[head_n[1:0]] = cfg.escape_char;
          head_n = head_n + 3'd1;
          head[head_n[1:0]] = item_r.data_byte;
          head_n = head_n + 3'd1;
        end else begin
          head[head_n[1:0]] = item_r.data_byte;
          head_n = head_n + 3'd1;
        end
      end
      if (item_r.field_end && enc_on) begin
        head[head_n[1:0]] = cfg.quote_char;
        head_n = head_n + 3'd1;
      end
    end
  end

  always_comb begin
    sep_word = item_r.row_end ? cfg.line_sep_bytes : cfg.field_sep_bytes;
    sep_len  = item_r.row_end ? cfg.line_sep_len : cfg.field_sep_len;
    if (sep_len > LIM_L) sep_len = LIM_L;
    sep_n   = item_r.field_end ? sep_len : 3'd0;
    run_cnt = CNT_W'(head_n) + CNT_W'(sep_n);
    k       = '0;
    for (int j = 0; j < RUN_MAX; j++) begin
      if (3'(j) < head_n) begin
        run_bytes[j] = head[2'(j)];
      end else begin
        k = 3'(j) - head_n;
        run_bytes[j] = sep_word[k[1:0]];
      end
    end
  end

  // items with an empty run pass without using the run slot
  assign take        = in_valid_r && ((run_cnt == '0) || slot_free);
  assign load        = in_valid_r && (run_cnt != '0) && slot_free;
  assign in_ch.ready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.data_byte     <= in_ch.data_byte;
      item_r.has_byte      <= in_ch.has_byte;
      item_r.field_start   <= in_ch.field_start;
      item_r.field_end     <= in_ch.field_end;
      item_r.is_null       <= in_ch.is_null;
      item_r.enclose_field <= in_ch.enclose_field;
      item_r.row_end       <= in_ch.row_end;
    end
  end

endmodule

FILE: hw/rtl/dfe_serial.sv
// run slot and output register: drains one byte of the run per cycle unless out_ch stalls
// depends on dfe_ifs
module dfe_serial #(
  parameter int unsigned RUN_MAX = 8,
  parameter int unsigned CNT_W   = 4,
  parameter int unsigned IDX_W   = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic [RUN_MAX-1:0][7:0] run_bytes,
  input  logic [CNT_W-1:0]        run_cnt,
  output logic                    slot_free,
  dfe_out_if.source               out_ch
);

  logic                    run_valid_r;
  logic [RUN_MAX-1:0][7:0] run_bytes_r;
  logic [CNT_W-1:0]        run_cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_last_r;
  logic                    out_can;
  logic                    step;
  logic                    at_last;
  logic                    run_done;

  assign out_can   = !out_valid_r || out_ch.ready;
  assign step      = run_valid_r && out_can;
  assign at_last   = (CNT_W'(idx_r) + CNT_W'(1)) == run_cnt_r;
  assign run_done  = step && at_last;
  assign slot_free = !run_valid_r || run_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) run_valid_r <= 1'b1;
      else if (run_done) run_valid_r <= 1'b0;
      if (step) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_bytes_r <= run_bytes;
      run_cnt_r   <= run_cnt;
      idx_r       <= '0;
    end else if (step) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (step) begin
      out_byte_r <= run_bytes_r[idx_r];
      out_last_r <= at_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (CNT_W'(idx_r) < run_cnt_r))
    else $error("run index past run length");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (run_cnt_r != '0))
    else $error("empty run held in slot");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!run_valid_r || run_done))
    else $error("run loaded over a busy slot");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    run_done |=> (out_valid_r && out_last_r))
    else $error("run end not marked on output");

endmodule

FILE: hw/rtl/delimited_field_escaper_top.sv
// top level of the delimited field escaper
// channel   dir  handshake      payload
// in_ch     in   valid/ready    data_byte, has_byte, field/row flags
// out_ch    out  valid/ready    out_byte, last_of_run
// cfg_*     in   write enable   cfg_index, cfg_data
// one output byte per cycle unless out_ch stalls; a run holds the run slot until its last byte is sent
// an item with no result bytes passes the input register without using the run slot
// a run reaches out_ch through the input register, the run slot and the output register
// reset clears all valid flags and loads the default configuration
// a stall on out_ch backs up through the run slot to in_ch.ready
// depends on dfe_pkg, dfe_ifs, dfe_cfg_regs, dfe_expand, dfe_serial
module delimited_field_escaper_top
  import dfe_pkg::*;
#(
  parameter int unsigned SEP_BYTES_MAX = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dfe_in_if.sink                in_ch,
  dfe_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned LIM     = (SEP_BYTES_MAX < SEP_HW_MAX) ? SEP_BYTES_MAX : SEP_HW_MAX;
  localparam int unsigned RUN_MAX = 4 + LIM;
  localparam int unsigned CNT_W   = $clog2(RUN_MAX + 1);
  localparam int unsigned IDX_W   = $clog2(RUN_MAX);

  cfg_t                    cfg;
  logic                    slot_free;
  logic                    load;
  logic [RUN_MAX-1:0][7:0] run_bytes;
  logic [CNT_W-1:0]        run_cnt;

  dfe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfe_expand #(
    .SEP_BYTES_MAX (SEP_BYTES_MAX),
    .RUN_MAX       (RUN_MAX),
    .CNT_W         (CNT_W)
  ) u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .slot_free (slot_free),
    .load      (load),
    .run_bytes (run_bytes),
    .run_cnt   (run_cnt)
  );

  dfe_serial #(
    .RUN_MAX (RUN_MAX),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .run_bytes (run_bytes),
    .run_cnt   (run_cnt),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

FILE: tb/sv/dfe_checker.sv
`timescale 1ns / 1ps
// output checker for the delimited field escaper: watches both channels and the register port,
// predicts the escaped text of every input transfer and compares it byte by byte
// depends on dfe_pkg
module dfe_checker
  import dfe_pkg::*;
#(
  parameter int unsigned SEP_BYTES_MAX = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  item_t                 in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_byte,
  input  logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           text_owed
);

  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } text_beat_t;

  cfg_t       regs;
  text_beat_t text_q[$];
  text_beat_t want;

  // escaped text of one input transfer, appended to the queue
  task automatic escape_item(input item_t it);
    logic [7:0]  run[$];
    logic        enc;
    logic [31:0] sep_bytes;
    logic [2:0]  sep_len;
    int unsigned sep_n;
    int unsigned lim;
    enc = it.enclose_field && (regs.quote_char != CH_NUL);
    if (it.is_null) begin
      run.push_back(regs.escape_char);
      run.push_back(CH_N);
    end else begin
      if (it.field_start && enc) run.push_back(regs.quote_char);
      if (it.has_byte) begin
        if (it.data_byte == CH_NUL) begin
          run.push_back(regs.escape_char);
          run.push_back(CH_ZERO);
        end else if (it.data_byte == CH_TAB || it.data_byte == CH_NL ||
                     it.data_byte == regs.escape_char ||
                     (regs.quote_char != CH_NUL && it.data_byte == regs.quote_char)) begin
          run.push_back(regs.escape_char);
          run.push_back(it.data_byte);
        end else begin
          run.push_back(it.data_byte);
        end
      end
      if (it.field_end && enc) run.push_back(regs.quote_char);
    end
    if (it.field_end) begin
      sep_bytes = it.row_end ? regs.line_sep_bytes : regs.field_sep_bytes;
      sep_len   = it.row_end ? regs.line_sep_len : regs.field_sep_len;
      lim       = (SEP_BYTES_MAX < SEP_HW_MAX) ? SEP_BYTES_MAX : SEP_HW_MAX;
      sep_n     = (sep_len > lim) ? lim : sep_len;
      for (int i = 0; i < sep_n; i++) run.push_back(8'(sep_bytes >> (8 * i)));
    end
    foreach (run[i]) text_q.push_back('{text: run[i], last: (i == run.size() - 1)});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.escape_char     = CH_BSLASH;
      regs.quote_char      = CH_NUL;
      regs.field_sep_bytes = {24'h0, CH_TAB};
      regs.field_sep_len   = 3'd1;
      regs.line_sep_bytes  = {24'h0, CH_NL};
      regs.line_sep_len    = 3'd1;
      mismatches           = 0;
      text_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ESCAPE_CHAR:     regs.escape_char = cfg_data[7:0];
          REG_QUOTE_CHAR:      regs.quote_char = cfg_data[7:0];
          REG_FIELD_SEP_BYTES: regs.field_sep_bytes = cfg_data;
          REG_FIELD_SEP_LEN:   regs.field_sep_len = cfg_data[2:0];
          REG_LINE_SEP_BYTES:  regs.line_sep_bytes = cfg_data;
          REG_LINE_SEP_LEN:    regs.line_sep_len = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) escape_item(in_item);
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dfe_checker: byte %02h last %0b with nothing predicted", out_byte,
                     out_last);
        end else begin
          want = text_q.pop_front();
          if (want.text !== out_byte || want.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("dfe_checker: expected byte %02h last %0b, got byte %02h last %0b",
                       want.text, want.last, out_byte, out_last);
          end
        end
      end
    end
    text_owed = text_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// top of the delimited field escaper testbench: clock, reset, stimulus and verdict
// drives directed and random rows under several register settings and flow patterns
// depends on dfe_pkg, dfe_ifs, delimited_field_escaper_top, dfe_checker
module tb;
  import dfe_pkg::*;

  localparam int unsigned SEP_MAX      = 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_SRC_GAPS,
    FLOW_SNK_STALLS,
    FLOW_BOTH
  } flow_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatches;
  int unsigned text_owed;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left = 0;
  logic [7:0]  esc_now = CH_BSLASH;
  logic [7:0]  enc_now = CH_NUL;

  dfe_in_if  in_ch ();
  dfe_out_if out_ch ();

  delimited_field_escaper_top #(.SEP_BYTES_MAX(SEP_MAX)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dfe_checker #(.SEP_BYTES_MAX(SEP_MAX)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    ({in_ch.data_byte, in_ch.has_byte, in_ch.field_start, in_ch.field_end,
                  in_ch.is_null, in_ch.enclose_field, in_ch.row_end}),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_last   (out_ch.last_of_run),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .text_owed  (text_owed)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // receiver: long hold-off when asked, else random stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  function automatic item_t mk_item(logic [7:0] d, logic has, logic fs, logic fe, logic nul,
                                    logic enc, logic re);
    item_t it;
    it.data_byte     = d;
    it.has_byte      = has;
    it.field_start   = fs;
    it.field_end     = fe;
    it.is_null       = nul;
    it.enclose_field = enc;
    it.row_end       = re;
    return it;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] hot [7];
    hot = '{CH_NUL, CH_TAB, CH_NL, CH_N, CH_ZERO, esc_now, enc_now};
    if ($urandom_range(99) < 40) return hot[3'($urandom_range(6))];
    return 8'($urandom_range(255));
  endfunction

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_FREE:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      FLOW_SRC_GAPS:   begin src_idle_pct = 88; snk_stall_pct = 0;  end
      FLOW_SNK_STALLS: begin src_idle_pct = 0;  snk_stall_pct = 88; end
      default:         begin src_idle_pct = 33; snk_stall_pct = 33; end
    endcase
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.data_byte     = it.data_byte;
    in_ch.has_byte      = it.has_byte;
    in_ch.field_start   = it.field_start;
    in_ch.field_end     = it.field_end;
    in_ch.is_null       = it.is_null;
    in_ch.enclose_field = it.enclose_field;
    in_ch.row_end       = it.row_end;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid = 1'b0;
    while (text_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] esc, input logic [7:0] enc,
                            input logic [31:0] fsep, input logic [2:0] flen,
                            input logic [31:0] lsep, input logic [2:0] llen);
    wait_drain();
    cfg_write(REG_ESCAPE_CHAR, {24'h0, esc});
    cfg_write(REG_QUOTE_CHAR, {24'h0, enc});
    cfg_write(REG_FIELD_SEP_BYTES, fsep);
    cfg_write(REG_FIELD_SEP_LEN, {29'h0, flen});
    cfg_write(REG_LINE_SEP_BYTES, lsep);
    cfg_write(REG_LINE_SEP_LEN, {29'h0, llen});
    // unmapped indexes must leave the registers alone
    cfg_write(REG_SPARE_A, '1);
    cfg_write(REG_SPARE_B, '1);
    esc_now = esc;
    enc_now = enc;
  endtask

  // enclosed field holding the enclosure, escape and NUL bytes, then an enclosed empty field at row end
  task automatic send_specials();
    send_item(mk_item(enc_now, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk_item(esc_now, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(mk_item(CH_NUL, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(mk_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
  endtask

  task automatic send_field(input logic row_last);
    int unsigned n;
    logic        enc;
    item_t       it;
    n   = $urandom_range(4);
    enc = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      it             = item_t'(14'($urandom));
      it.is_null     = 1'b1;
      it.field_start = 1'b1;
      it.field_end   = 1'b1;
      it.row_end     = row_last;
      send_item(it);
    end else if (n == 0) begin
      send_item(mk_item(8'($urandom), 1'b0, 1'b1, 1'b1, 1'b0, enc, row_last));
    end else begin
      for (int i = 0; i < n; i++)
        send_item(mk_item(pick_byte(), 1'b1, i == 0, i == n - 1, 1'b0, enc, row_last));
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned target;
    int unsigned nf;
    target = items_sent + n;
    while (items_sent < target) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if ($urandom_range(99) < 12) send_item(item_t'(14'($urandom)));
        send_field(f == nf - 1);
      end
    end
  endtask

  task automatic run_flows(input int unsigned n);
    flow_t f;
    f = f.first();
    do begin
      set_flow(f);
      run_random(n);
      f = f.next();
    end while (f != f.first());
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = 8'h00;
    in_ch.has_byte      = 1'b0;
    in_ch.field_start   = 1'b0;
    in_ch.field_end     = 1'b0;
    in_ch.is_null       = 1'b0;
    in_ch.enclose_field = 1'b0;
    in_ch.row_end       = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_ESCAPE_CHAR;
    cfg_data            = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: null, empty, every special byte, no-output item, disabled enclosure
    set_flow(FLOW_FREE);
    send_item(mk_item(8'hA5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    send_item(mk_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(CH_NUL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(CH_TAB, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(CH_NL, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(CH_N, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(mk_item(8'h22, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0));
    send_item(mk_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(mk_item(8'h7F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
    send_item(mk_item(8'hFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));

    // quoted fields, comma separator, three byte line terminator
    set_config(CH_BSLASH, 8'h22, 32'h0000002C, 3'd1, 32'h007E0A0D, 3'd3);
    send_specials();
    set_flow(FLOW_FREE);
    hold_left = HOLD_CYCLES;
    run_random(12);
    wait_drain();
    run_flows(2);

    // zero escape, all-ones enclosure, oversized and empty terminators
    set_config(8'h00, 8'hFF, 32'hFFFFFFFF, 3'd7, 32'h00000000, 3'd0);
    send_specials();
    run_flows(2);

    // all-ones escape, enclosure off, full width terminators
    set_config(8'hFF, 8'h00, 32'h04030201, 3'd4, 32'hDEADBEEF, 3'd5);
    send_specials();
    run_flows(2);

    wait_drain();
    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

FILE: delimited_field_escaper_top.f
hw/rtl/dfe_pkg.sv
hw/rtl/dfe_ifs.sv
hw/rtl/dfe_cfg_regs.sv
hw/rtl/dfe_expand.sv
hw/rtl/dfe_serial.sv
hw/rtl/delimited_field_escaper_top.sv
tb/sv/dfe_checker.sv
tb/sv/tb.sv
